/* rtl/detector_pixel_scatter_angles_unit_assert.svh */
// Assertion macros shared by the detector pixel angle RTL.
`ifndef DETECTOR_PIXEL_SCATTER_ANGLES_UNIT_ASSERT_SVH
`define DETECTOR_PIXEL_SCATTER_ANGLES_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define DPSA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication between two conditions on the same edge.
`define DPSA_IMPLIES(lbl, ante, cons, msg) \
   `DPSA_CHECK(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/dpsa_pkg.sv */
package dpsa_pkg;

   // Width of the CORDIC datapath, wide enough for the gain growth on both angles.
   localparam int CordicW = 42;
   // Angle accumulator width in 1/262144 degree.
   localparam int AngleW = 29;
   localparam int CordicSteps = 24;

   localparam logic signed [AngleW-1:0] HALF_TURN = 29'sd47185920;
   localparam logic [15:0] INV_GAIN = 16'd39797;
   localparam logic signed [21:0] TTH_MAX = 22'sd184320;
   localparam logic signed [21:0] GMA_MAX = 22'sd184320;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_COS_TILT   = 3'd0,
      REG_SIN_TILT   = 3'd1,
      REG_DISTANCE   = 3'd2,
      REG_PITCH      = 3'd3,
      REG_CENTER_COL = 3'd4,
      REG_CENTER_ROW = 3'd5
   } reg_index_type;

   // Arctangent of 2^-i in 1/262144 degree.
   localparam logic signed [AngleW-1:0] ATAN_TAB [CordicSteps] = '{
      29'sd11796480, 29'sd6963869, 29'sd3679517, 29'sd1867780, 29'sd937515,
      29'sd469214, 29'sd234664, 29'sd117339, 29'sd58671, 29'sd29335,
      29'sd14668, 29'sd7334, 29'sd3667, 29'sd1833, 29'sd917, 29'sd458,
      29'sd229, 29'sd115, 29'sd57, 29'sd29, 29'sd14, 29'sd7, 29'sd4, 29'sd2
   };

endpackage

/* rtl/dpsa_cordic.sv */
// Pipelined CORDIC vectoring unit: one half-plane fold stage, then one stage per step.
module dpsa_cordic #(
   parameter int SIDE_W = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [dpsa_pkg::CordicW-1:0]   in_x,
   input  logic signed [dpsa_pkg::CordicW-1:0]   in_y,
   input  logic [SIDE_W-1:0]                     in_side,
   output logic                                  out_valid,
   output logic signed [dpsa_pkg::CordicW-1:0]   out_mag,
   output logic signed [dpsa_pkg::AngleW-1:0]    out_angle,
   output logic [SIDE_W-1:0]                     out_side
);

   localparam int N = dpsa_pkg::CordicSteps;

   logic                                 v_ff    [0:N];
   logic                                 zero_ff [0:N];
   logic signed [dpsa_pkg::CordicW-1:0]  x_ff    [0:N];
   logic signed [dpsa_pkg::CordicW-1:0]  y_ff    [0:N];
   logic signed [dpsa_pkg::AngleW-1:0]   z_ff    [0:N];
   logic [SIDE_W-1:0]                    side_ff [0:N];

   // Fold a left half-plane vector into the right half-plane.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         side_ff[0] <= in_side;
         if (in_x < 0) begin
            x_ff[0] <= -in_x;
            y_ff[0] <= -in_y;
            z_ff[0] <= (in_y >= 0) ? dpsa_pkg::HALF_TURN : -dpsa_pkg::HALF_TURN;
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [dpsa_pkg::CordicW-1:0] tx, ty;
      assign tx = x_ff[k] >>> k;
      assign ty = y_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (y_ff[k] < 0) begin
               x_ff[k+1] <= x_ff[k] - ty;
               y_ff[k+1] <= y_ff[k] + tx;
               z_ff[k+1] <= z_ff[k] - dpsa_pkg::ATAN_TAB[k];
            end else begin
               x_ff[k+1] <= x_ff[k] + ty;
               y_ff[k+1] <= y_ff[k] - tx;
               z_ff[k+1] <= z_ff[k] + dpsa_pkg::ATAN_TAB[k];
            end
         end
      end
   end

   // A zero vector keeps zero length on its own; only its angle is forced.
   assign out_valid = v_ff[N];
   assign out_mag   = x_ff[N];
   assign out_angle = zero_ff[N] ? '0 : z_ff[N];
   assign out_side  = side_ff[N];

endmodule

/* rtl/detector_pixel_scatter_angles_unit.sv */
// Channel   Direction  Payload (low bit first)
// req_*     in         tdata: col[11:0], row[23:12]
// rsp_*     out        tdata: two_theta[17:0], gamma[36:18], zero pad to 40 bits
// csr_*     in         index[2:0], data[31:0]: one configuration register per beat
//
// One pixel enters per clock while req_tready is high, that is while the spare entry is free.
// The pipeline holds the two CORDIC pipelines of 25 stages each (a half-plane fold
// and 24 steps) plus six arithmetic and output stages.
// Reset clears all valid bits and loads the register defaults (no tilt, 1000 mm, 1 mm pitch).
// A stall at rsp_* is absorbed by a two-entry output buffer; the pipeline freezes as a
// whole only when the spare entry is full, so no beat is lost or repeated.
module detector_pixel_scatter_angles_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // col[11:0], row[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // two_theta[17:0], gamma[36:18], zeros above
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   `include "detector_pixel_scatter_angles_unit_assert.svh"

   localparam int CW = dpsa_pkg::CordicW;
   localparam int AW = dpsa_pkg::AngleW;
   localparam logic [14:0] DIM_LIM = 15'(MAX_DIM - 1);

   // Configuration registers.
   logic signed [17:0] cos_tilt_ff, sin_tilt_ff;
   logic [31:0]        distance_ff;
   logic [19:0]        pitch_ff;
   logic signed [13:0] center_col_ff, center_row_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_tilt_ff   <= 18'sd65536;
         sin_tilt_ff   <= '0;
         distance_ff   <= 32'd65536000;
         pitch_ff      <= 20'd65536;
         center_col_ff <= 14'sd2048;
         center_row_ff <= 14'sd2048;
      end else if (csr_valid) begin
         unique case (csr_index)
            dpsa_pkg::REG_COS_TILT:   cos_tilt_ff   <= csr_data[17:0];
            dpsa_pkg::REG_SIN_TILT:   sin_tilt_ff   <= csr_data[17:0];
            dpsa_pkg::REG_DISTANCE:   distance_ff   <= csr_data;
            dpsa_pkg::REG_PITCH:      pitch_ff      <= csr_data[19:0];
            dpsa_pkg::REG_CENTER_COL: center_col_ff <= csr_data[13:0];
            dpsa_pkg::REG_CENTER_ROW: center_row_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless the output spare entry is occupied.
   logic skid_v_ff;
   logic en;
   assign en = !skid_v_ff;
   assign req_tready = en;

   // Stage 1: clamp the pixel and take its offset from the beam center.
   logic [11:0] col_c, row_c;
   logic               s1_v_ff;
   logic signed [14:0] dcol_ff, drow_ff;

   assign col_c = ({3'b0, req_tdata[11:0]} > DIM_LIM) ? DIM_LIM[11:0] : req_tdata[11:0];
   assign row_c = ({3'b0, req_tdata[23:12]} > DIM_LIM) ? DIM_LIM[11:0] : req_tdata[23:12];

   // Stage 2: scale by the pixel pitch.
   logic               s2_v_ff;
   logic signed [35:0] dx_ff, by2_ff;

   // Stage 3: the four tilt products.
   logic               s3_v_ff;
   logic signed [53:0] p_ds_ff, p_dc_ff, p_xc_ff, p_xs_ff;
   logic signed [35:0] by3_ff;

   // Stage 4: rotated beam vector, floor-shifted back to 1/65536 mm.
   logic               s4_v_ff;
   logic signed [CW-1:0] bx_ff, bz_ff, by4_ff;
   logic signed [54:0] sum_x, sum_z;

   assign sum_x = 55'(p_ds_ff) + 55'(p_xc_ff);
   assign sum_z = 55'(p_dc_ff) - 55'(p_xs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
      if (en) begin
         dcol_ff <= $signed({3'b0, col_c}) - 15'(center_col_ff);
         drow_ff <= 15'(center_row_ff) - $signed({3'b0, row_c});
         dx_ff   <= 36'(dcol_ff) * $signed({16'b0, pitch_ff});
         by2_ff  <= 36'(drow_ff) * $signed({16'b0, pitch_ff});
         p_ds_ff <= 54'($signed({1'b0, distance_ff})) * 54'(sin_tilt_ff);
         p_dc_ff <= 54'($signed({1'b0, distance_ff})) * 54'(cos_tilt_ff);
         p_xc_ff <= 54'(dx_ff) * 54'(cos_tilt_ff);
         p_xs_ff <= 54'(dx_ff) * 54'(sin_tilt_ff);
         by3_ff  <= by2_ff;
         bx_ff   <= CW'(sum_x >>> 16);
         bz_ff   <= CW'(sum_z >>> 16);
         by4_ff  <= CW'(by3_ff);
      end
   end

   // Gamma: angle of (b_x, b_y); its length is the radial component.
   logic              g_v;
   logic signed [CW-1:0] g_mag, g_bz;
   logic signed [AW-1:0] g_angle;

   dpsa_cordic #(.SIDE_W(CW)) u_gamma (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_v_ff),
      .in_x      (bx_ff),
      .in_y      (by4_ff),
      .in_side   (bz_ff),
      .out_valid (g_v),
      .out_mag   (g_mag),
      .out_angle (g_angle),
      .out_side  (g_bz)
   );

   // Remove the CORDIC gain from the radial length.
   logic              gn_v_ff;
   logic [56:0]       gn_prod_ff;
   logic signed [CW-1:0] gn_bz_ff;
   logic signed [AW-1:0] gn_gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gn_v_ff <= 1'b0;
      end else if (en) begin
         gn_v_ff <= g_v;
      end
      if (en) begin
         gn_prod_ff  <= 57'(g_mag[CW-2:0]) * 57'(dpsa_pkg::INV_GAIN);
         gn_bz_ff    <= g_bz;
         gn_gamma_ff <= g_angle;
      end
   end

   // Two-theta: angle of (b_z, radial length).
   logic              t_v;
   logic signed [CW-1:0] t_mag, t_r;
   logic signed [AW-1:0] t_angle, t_gamma;

   assign t_r = $signed({1'b0, gn_prod_ff[56:16]});

   dpsa_cordic #(.SIDE_W(AW)) u_theta (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (gn_v_ff),
      .in_x      (gn_bz_ff),
      .in_y      (t_r),
      .in_side   (gn_gamma_ff),
      .out_valid (t_v),
      .out_mag   (t_mag),
      .out_angle (t_angle),
      .out_side  (t_gamma)
   );

   // Round to 1/1024 degree and clamp.
   logic signed [AW:0] rt_sum, rg_sum, rt_a, rg_a;
   logic [17:0]        tth_val;
   logic signed [18:0] gma_val;
   logic [36:0]        res;
   logic               res_v;

   assign rt_sum = (AW+1)'(t_angle) + (AW+1)'(128);
   assign rg_sum = (AW+1)'(t_gamma) + (AW+1)'(128);
   assign rt_a   = rt_sum >>> 8;
   assign rg_a   = rg_sum >>> 8;

   always_comb begin
      priority if (rt_a < 0) begin
         tth_val = '0;
      end else if (rt_a > (AW+1)'(dpsa_pkg::TTH_MAX)) begin
         tth_val = 18'(dpsa_pkg::TTH_MAX);
      end else begin
         tth_val = rt_a[17:0];
      end
      priority if (rg_a < -(AW+1)'(dpsa_pkg::GMA_MAX)) begin
         gma_val = -19'(dpsa_pkg::GMA_MAX);
      end else if (rg_a > (AW+1)'(dpsa_pkg::GMA_MAX)) begin
         gma_val = 19'(dpsa_pkg::GMA_MAX);
      end else begin
         gma_val = rg_a[18:0];
      end
   end

   assign res   = {gma_val, tth_val};
   assign res_v = en && t_v;

   // Output register plus one spare entry.
   logic        out_v_ff;
   logic [36:0] out_ff, skid_ff;
   logic        take;

   assign take = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= res_v;
         end else begin
            out_v_ff <= res_v;
         end
      end else if (res_v) begin
         skid_v_ff <= 1'b1;
      end
      if (take || !out_v_ff) begin
         out_ff  <= skid_v_ff ? skid_ff : res;
         skid_ff <= res;
      end else if (res_v) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'b0, out_ff};

   `DPSA_IMPLIES(a_skid_needs_out, skid_v_ff, out_v_ff, "spare entry full while output empty")
   `DPSA_IMPLIES(a_no_entry_when_full, skid_v_ff, !req_tready, "input accepted with spare full")
   `DPSA_IMPLIES(a_tth_range, rsp_tvalid, out_ff[17:0] <= 18'd184320, "two_theta out of range")
   `DPSA_IMPLIES(a_zero_len, t_v && (t_mag < 0), 1'b0, "negative CORDIC length")

endmodule
